/* hdl/ordered_list_engine_core_macros.svh */
// Assertion macros shared by the ordered list engine RTL.
// Each macro assumes signals clk and rst_n in the scope that uses it.
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define OLEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define OLEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/olec_pkg.sv */
// Package for the ordered list engine: widths, request and status codes,
// cell operation codes, FSM states and the cell control struct. No dependencies.
`timescale 1ns / 1ps
package olec_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned STAT_W       = 3;

  // Request codes
  typedef enum logic [MODE_W-1:0] {
    MD_INS_FRONT,
    MD_INS_END,
    MD_INS_POS,
    MD_DEL_FRONT,
    MD_DEL_END,
    MD_DEL_POS,
    MD_DEL_VAL,
    MD_DUMP
  } mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_BOUNDS,
    ST_NOTFOUND,
    ST_FULL
  } status_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,  // keep value
    OP_INS,   // open a gap at the index, shift right
    OP_DEL,   // close the gap at the index, shift left
    OP_ROT    // rotate the occupied part left by one
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_EXEC,
    S_DUMP
  } state_t;

  // Broadcast to the whole row of cells
  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  value;
  } cell_ctl_t;

endpackage

/* hdl/olec_cell.sv */
// One storage cell of the list row: holds one element, shifts to and from
// its neighbours and compares against the request value. Uses olec_pkg.
`timescale 1ns / 1ps
module olec_cell import olec_pkg::*; #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [IDX_W-1:0]        at,
  input  logic [IDX_W-1:0]        last_idx,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic signed [VAL_W-1:0] head_value,
  output logic signed [VAL_W-1:0] value,
  output logic                    match
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    match_r;

  // next element held here
  always_comb begin
    value_nxt = value_r;
    unique case (ctl.op)
      OP_HOLD: value_nxt = value_r;
      OP_INS: begin
        if (MY_IDX > at) value_nxt = left_value;
        else if (MY_IDX == at) value_nxt = ctl.value;
      end
      OP_DEL: begin
        if (MY_IDX >= at) value_nxt = right_value;
      end
      OP_ROT: value_nxt = (MY_IDX == last_idx) ? head_value : right_value;
      default: value_nxt = value_r;
    endcase
  end

  // storage and registered compare
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    match_r <= (value_r == ctl.value);
  end

  assign value = value_r;
  assign match = match_r;

endmodule

/* hdl/ordered_list_engine_core.sv */
// Ordered list engine: bounded list of signed 32-bit values in a row of cells.
// A request is captured, then passes S_SRCH and S_EXEC to its registered result beat
// (capture, registered compare in every cell, first-match pick and shift);
// a dump's beats come from S_DUMP, one per cycle while out_stall is low.
// A new request is taken only in S_IDLE, after the last one has finished.
// Reset clears length and control; cell contents are not cleared.
`timescale 1ns / 1ps
module ordered_list_engine_core import olec_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STAT_W-1:0]       out_status,
  output logic signed [VAL_W-1:0] out_value,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_last
);

`include "ordered_list_engine_core_macros.svh"

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int unsigned PAD_W = IDX_W + POS_W;

  state_t                  state_r, state_nxt;
  mode_t                   req_mode_r;
  logic signed [VAL_W-1:0] req_value_r;
  logic [POS_W-1:0]        req_pos_r;
  logic [LEN_W-1:0]        len_r;
  logic [IDX_W-1:0]        dump_cnt_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [POS_W-1:0]        out_position_r;
  logic                    out_last_r;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]     cell_match;
  logic [CAPACITY-1:0]     hit_vec;
  cell_ctl_t               ctl;

  logic                    in_fire, out_free, full, empty;
  logic [IDX_W-1:0]        len_idx, last_idx, pos_idx, fidx;
  logic [CMP_W-1:0]        pos_cmp, len_cmp;
  logic                    found;
  cell_op_t                dec_op;
  logic [IDX_W-1:0]        dec_at;
  status_t                 dec_status;
  logic                    dec_dump;
  logic signed [VAL_W-1:0] sel_value;
  logic                    dump_last;

  logic                    emit;
  status_t                 emit_status;
  logic signed [VAL_W-1:0] emit_value;
  logic [PAD_W-1:0]        emit_pad;
  logic                    emit_last;
  cell_op_t                cell_op;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (len_r == LEN_W'(CAPACITY));
  assign empty    = (len_r == '0);
  assign len_idx  = IDX_W'(len_r);
  assign last_idx = IDX_W'(len_r - LEN_W'(1));
  assign pos_idx  = IDX_W'(req_pos_r);
  assign pos_cmp  = CMP_W'(req_pos_r);
  assign len_cmp  = CMP_W'(len_r);
  assign dump_last = (dump_cnt_r == last_idx);

  // row of cells
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VAL_W-1:0] left_v, right_v;
      if (g == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_value[g+1];
      end
      olec_cell #(
        .IDX_W (IDX_W),
        .INDEX (g)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .at          (dec_at),
        .last_idx    (last_idx),
        .left_value  (left_v),
        .right_value (right_v),
        .head_value  (cell_value[0]),
        .value       (cell_value[g]),
        .match       (cell_match[g])
      );
      assign hit_vec[g] = cell_match[g] && (LEN_W'(g) < len_r);
    end
  endgenerate

  // first occupied cell that matched
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        found = 1'b1;
        fidx  = IDX_W'(i);
      end
    end
  end

  // request decode: what to do to the row and what to report
  always_comb begin
    dec_op     = OP_HOLD;
    dec_at     = '0;
    dec_status = ST_OK;
    dec_dump   = 1'b0;
    unique case (req_mode_r)
      MD_INS_FRONT: begin
        if (full) dec_status = ST_FULL;
        else dec_op = OP_INS;
      end
      MD_INS_END: begin
        if (full) dec_status = ST_FULL;
        else begin
          dec_op = OP_INS;
          dec_at = len_idx;
        end
      end
      MD_INS_POS: begin
        if (full) dec_status = ST_FULL;
        else if (empty) dec_op = OP_INS;
        else if (pos_cmp > len_cmp) dec_status = ST_BOUNDS;
        else begin
          dec_op = OP_INS;
          dec_at = pos_idx;
        end
      end
      MD_DEL_FRONT: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_op = OP_DEL;
      end
      MD_DEL_END: begin
        if (empty) dec_status = ST_EMPTY;
        else begin
          dec_op = OP_DEL;
          dec_at = last_idx;
        end
      end
      MD_DEL_POS: begin
        if (empty) dec_status = ST_EMPTY;
        else if (pos_cmp >= len_cmp) dec_status = ST_BOUNDS;
        else begin
          dec_op = OP_DEL;
          dec_at = pos_idx;
        end
      end
      MD_DEL_VAL: begin
        if (found) begin
          dec_op = OP_DEL;
          dec_at = fidx;
        end else dec_status = ST_NOTFOUND;
      end
      MD_DUMP: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_dump = 1'b1;
      end
      default: dec_status = ST_OK;
    endcase
  end

  // element being removed
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IDX_W'(i) == dec_at) sel_value = sel_value | cell_value[i];
    end
  end

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SRCH;
      S_SRCH: state_nxt = S_EXEC;
      S_EXEC: begin
        if (out_free) state_nxt = dec_dump ? S_DUMP : S_IDLE;
      end
      S_DUMP: if (out_free && dump_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs: result beat and row operation
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;
    emit_pad    = '0;
    emit_last   = 1'b1;
    cell_op     = OP_HOLD;
    unique case (state_r)
      S_EXEC: begin
        if (out_free) begin
          emit        = !dec_dump;
          emit_status = dec_status;
          cell_op     = dec_op;
          if (dec_status == ST_OK) begin
            emit_value = (dec_op == OP_DEL) ? sel_value : req_value_r;
            emit_pad   = PAD_W'(dec_at);
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_value = cell_value[0];
          emit_pad   = PAD_W'(dump_cnt_r);
          emit_last  = dump_last;
          cell_op    = OP_ROT;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign ctl.op    = cell_op;
  assign ctl.value = req_value_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cell_op == OP_INS) len_r <= len_r + LEN_W'(1);
      else if (cell_op == OP_DEL) len_r <= len_r - LEN_W'(1);
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // request capture, dump counter and result beat payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_mode_r  <= mode_t'(in_mode);
      req_value_r <= in_item_value;
      req_pos_r   <= in_position;
    end
    if (state_r == S_EXEC) dump_cnt_r <= '0;
    else if (state_r == S_DUMP && out_free) dump_cnt_r <= dump_cnt_r + IDX_W'(1);
    if (emit) begin
      out_status_r   <= emit_status;
      out_value_r    <= emit_value;
      out_position_r <= emit_pad[POS_W-1:0];
      out_last_r     <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_value    = out_value_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;

  // checks
  `OLEC_ASSERT_IMP(a_len_bound, 1'b1, len_r <= LEN_W'(CAPACITY), "length above capacity")
  `OLEC_ASSERT_NXT(a_accept_srch, in_fire, state_r == S_SRCH, "accept did not start search")
  `OLEC_ASSERT_NXT(a_ins_grow, cell_op == OP_INS, len_r == $past(len_r) + LEN_W'(1), "insert lost")
  `OLEC_ASSERT_IMP(a_dump_nonempty, state_r == S_DUMP, len_r != '0, "dump of empty list")

endmodule
